@@ hdl/sptg_pkg.sv @@
// Shared types and constants for the step pulse train generator.
// Used by every module under hdl; no dependencies.
package sptg_pkg;

    localparam int BLOCK_STEPS_DEF      = 64;
    localparam int TICKS_PER_SECOND_DEF = 1000000;

    localparam int CNT_W    = 31;
    localparam int FREQ_W   = 20;
    localparam int PERIOD_W = 18;
    localparam int CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] HIGH_TICKS = PERIOD_W'(2);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(4);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(262143);
    localparam logic [FREQ_W-1:0]   MIN_FREQ   = FREQ_W'(16);

    localparam logic [CNT_W-1:0]  TOTAL_RST = CNT_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_RST  = FREQ_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FREQ_HZ = CFG_IDX_W'(1);

    typedef struct packed {
        logic start_req;
        logic stop_req;
    } t_in_word;

    typedef struct packed {
        logic             step_level;
        logic             busy_res;
        logic [CNT_W-1:0] steps_completed;
        logic             start_rejected;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic div_start;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

@@ hdl/sptg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on sptg_pkg for the divisor width.
module sptg_div #(
    parameter int DVD_W = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DVD_W-1:0]              i_dividend,
    input  logic [sptg_pkg::FREQ_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [DVD_W-1:0]              o_quot
);

    localparam int FW = sptg_pkg::FREQ_W;
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quot, n_quot;
    logic [FW-1:0]    r_rem, n_rem;
    logic [FW-1:0]    r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [FW:0]      rem_sh;
    logic [FW:0]      rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = (rem_sh >= {1'b0, r_dvs});
        n_rem   = ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
        n_quot  = {r_quot[DVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/sptg_dp.sv @@
// Datapath: config registers, train state, period divider and result register.
// Depends on sptg_pkg and sptg_div.
module sptg_dp #(
    parameter int BLOCK_STEPS      = sptg_pkg::BLOCK_STEPS_DEF,
    parameter int TICKS_PER_SECOND = sptg_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sptg_pkg::t_cmd                    i_cmd,
    output sptg_pkg::t_sts                    o_sts,
    input  sptg_pkg::t_in_word                i_in_word,
    input  logic                              i_cfg_we,
    input  logic [sptg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sptg_pkg::CNT_W-1:0]        i_cfg_data,
    output sptg_pkg::t_out_word               o_out_word
);

    localparam int CW   = sptg_pkg::CNT_W;
    localparam int FW   = sptg_pkg::FREQ_W;
    localparam int PW   = sptg_pkg::PERIOD_W;
    localparam int TW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int QW   = (TW > PW) ? TW : PW;
    localparam int SIBW = $clog2(BLOCK_STEPS + 1);

    logic [CW-1:0]   r_total;
    logic [FW-1:0]   r_freq;
    sptg_pkg::t_in_word  r_in;
    sptg_pkg::t_out_word r_out, n_out;

    logic            r_run, n_run;
    logic [PW-1:0]   r_period, n_period;
    logic [PW-1:0]   r_tip, n_tip;
    logic [CW-1:0]   r_rem, n_rem;
    logic [SIBW-1:0] r_sib, n_sib;
    logic [CW-1:0]   r_done, n_done;

    logic [FW-1:0]   divisor;
    logic [TW-1:0]   quot;
    logic            div_done;
    logic [QW-1:0]   q_ext;
    logic [PW-1:0]   p_sat;
    logic [PW-1:0]   p_calc;
    logic [PW-1:0]   tip_inc;
    logic [SIBW-1:0] sib_inc;
    logic [CW-1:0]   rem_dec;
    logic            cfg_zero;

    assign divisor  = (r_freq < sptg_pkg::MIN_FREQ) ? sptg_pkg::MIN_FREQ : r_freq;
    assign cfg_zero = (r_total == '0) || (r_freq == '0);

    sptg_div #(
        .DVD_W (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (TW'(TICKS_PER_SECOND)),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        q_ext  = QW'(quot);
        p_sat  = (q_ext > QW'(sptg_pkg::PERIOD_MAX)) ? sptg_pkg::PERIOD_MAX : q_ext[PW-1:0];
        p_calc = (p_sat < sptg_pkg::MIN_PERIOD) ? sptg_pkg::MIN_PERIOD : p_sat;
    end

    always_comb begin
        n_run    = r_run;
        n_period = r_period;
        n_tip    = r_tip;
        n_rem    = r_rem;
        n_sib    = r_sib;
        n_done   = r_done;
        n_out    = '0;
        tip_inc  = r_tip + 1'b1;
        sib_inc  = r_sib + 1'b1;
        rem_dec  = (r_rem != '0) ? (r_rem - 1'b1) : '0;

        if (r_run) begin
            if (r_in.stop_req) begin
                n_run = 1'b0;
                n_tip = '0;
                n_rem = '0;
                n_sib = '0;
            end else begin
                n_out.busy_res   = 1'b1;
                n_out.step_level = (r_tip < sptg_pkg::HIGH_TICKS);
                if (tip_inc >= r_period) begin
                    n_tip = '0;
                    n_rem = rem_dec;
                    if ((sib_inc == SIBW'(BLOCK_STEPS)) || (rem_dec == '0)) begin
                        n_done = r_done + CW'(sib_inc);
                        n_sib  = '0;
                    end else begin
                        n_sib = sib_inc;
                    end
                    if (rem_dec == '0) begin
                        n_run = 1'b0;
                    end
                end else begin
                    n_tip = tip_inc;
                end
            end
        end

        if (r_in.start_req) begin
            if (r_run || cfg_zero) begin
                n_out.start_rejected = 1'b1;
            end else begin
                n_period         = p_calc;
                n_tip            = PW'(1);
                n_rem            = r_total;
                n_sib            = '0;
                n_done           = '0;
                n_run            = 1'b1;
                n_out.busy_res   = 1'b1;
                n_out.step_level = 1'b1;
            end
        end

        n_out.steps_completed = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= sptg_pkg::TOTAL_RST;
            r_freq   <= sptg_pkg::FREQ_RST;
            r_run    <= 1'b0;
            r_period <= sptg_pkg::MIN_PERIOD;
            r_tip    <= '0;
            r_rem    <= '0;
            r_sib    <= '0;
            r_done   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sptg_pkg::REG_TOTAL_STEPS:  r_total <= i_cfg_data;
                    sptg_pkg::REG_STEP_FREQ_HZ: r_freq  <= i_cfg_data[FW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                r_run    <= n_run;
                r_period <= n_period;
                r_tip    <= n_tip;
                r_rem    <= n_rem;
                r_sib    <= n_sib;
                r_done   <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.apply) begin
            r_out <= n_out;
        end
    end

    assign o_sts.need_div = i_in_word.start_req && !r_run && !cfg_zero;
    assign o_sts.div_done = div_done;
    assign o_out_word     = r_out;

endmodule

@@ hdl/sptg_ctrl.sv @@
// Controller state machine: handshakes and datapath commands.
// Depends on sptg_pkg.
module sptg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  sptg_pkg::t_sts  i_sts,
    output sptg_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_APPLY,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

@@ hdl/step_pulse_train_generator_unit.sv @@
// Step pulse train generator, top level; one input word per tick, one result word each.
// An accepted word is loaded, applied and then presented as a valid result; a start taken
// while idle (nonzero config) first runs the period divider, one quotient bit per cycle.
// Words are handled one at a time: no new word is accepted until the divider, if needed,
// has finished and the result word has been taken.
// Reset (synchronous, active low): idle, total_steps 1, step_freq_hz 1000.
module step_pulse_train_generator_unit #(
    parameter int BLOCK_STEPS      = sptg_pkg::BLOCK_STEPS_DEF,
    parameter int TICKS_PER_SECOND = sptg_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sptg_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sptg_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sptg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sptg_pkg::CNT_W-1:0]        i_cfg_data
);

    sptg_pkg::t_cmd cmd;
    sptg_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    sptg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sptg_dp #(
        .BLOCK_STEPS      (BLOCK_STEPS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_word  (o_out_word)
    );

endmodule

@@ bench/testbench.sv @@
// Testbench for step_pulse_train_generator_unit: drives tick words and register writes,
// predicts each result word and checks it field by field. Depends on sptg_pkg.
// Runs a directed opening, then random phases; phases 0-3 stall sender and receiver.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class step_train_tracker;
        logic [sptg_pkg::CNT_W-1:0]    total_steps;
        logic [sptg_pkg::FREQ_W-1:0]   step_freq;
        logic                          running;
        logic [sptg_pkg::PERIOD_W-1:0] period;
        logic [sptg_pkg::PERIOD_W-1:0] tick;
        logic [sptg_pkg::CNT_W-1:0]    remaining;
        logic [6:0]                    in_block;
        logic [sptg_pkg::CNT_W-1:0]    done_steps;
        sptg_pkg::t_out_word           expected_ticks[$];
        int unsigned                   mismatches;

        function new();
            total_steps = sptg_pkg::TOTAL_RST;
            step_freq   = sptg_pkg::FREQ_RST;
            running     = 1'b0;
            period      = sptg_pkg::MIN_PERIOD;
            tick        = '0;
            remaining   = '0;
            in_block    = '0;
            done_steps  = '0;
            mismatches  = 0;
        endfunction

        function void set_config(logic [sptg_pkg::CNT_W-1:0] total,
                                 logic [sptg_pkg::FREQ_W-1:0] freq);
            total_steps = total;
            step_freq   = freq;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function logic step_once();
            logic level;
            level = (tick < sptg_pkg::HIGH_TICKS);
            tick++;
            if (tick >= period) begin
                tick = '0;
                in_block++;
                if (remaining != 0)
                    remaining--;
                if (in_block >= sptg_pkg::BLOCK_STEPS_DEF || remaining == 0) begin
                    done_steps = done_steps + sptg_pkg::CNT_W'(in_block);
                    in_block   = '0;
                end
                if (remaining == 0)
                    running = 1'b0;
            end
            return level;
        endfunction

        function void note_tick(sptg_pkg::t_in_word w);
            sptg_pkg::t_out_word         want;
            logic                        was_busy;
            logic [sptg_pkg::FREQ_W-1:0] f;
            int unsigned                 p;
            want     = '0;
            was_busy = running;
            if (running) begin
                if (w.stop_req) begin
                    running   = 1'b0;
                    tick      = '0;
                    remaining = '0;
                    in_block  = '0;
                end else begin
                    want.busy_res   = 1'b1;
                    want.step_level = step_once();
                end
            end
            if (w.start_req) begin
                if (was_busy || total_steps == 0 || step_freq == 0) begin
                    want.start_rejected = 1'b1;
                end else begin
                    f = (step_freq < sptg_pkg::MIN_FREQ) ? sptg_pkg::MIN_FREQ : step_freq;
                    p = sptg_pkg::TICKS_PER_SECOND_DEF / f;
                    if (p < sptg_pkg::MIN_PERIOD)
                        p = 32'(sptg_pkg::MIN_PERIOD);
                    if (p > sptg_pkg::PERIOD_MAX)
                        p = 32'(sptg_pkg::PERIOD_MAX);
                    period     = sptg_pkg::PERIOD_W'(p);
                    tick       = '0;
                    remaining  = total_steps;
                    in_block   = '0;
                    done_steps = '0;
                    running    = 1'b1;
                    want.busy_res   = 1'b1;
                    want.step_level = step_once();
                end
            end
            want.steps_completed = done_steps;
            expected_ticks.push_back(want);
        endfunction

        function void check_word(sptg_pkg::t_out_word got);
            sptg_pkg::t_out_word want;
            if (expected_ticks.size() == 0) begin
                $error("result word with nothing expected: %p", got);
                mismatches++;
                return;
            end
            want = expected_ticks.pop_front();
            if (got.step_level !== want.step_level) begin
                $error("step_level: expected %0d, got %0d", want.step_level, got.step_level);
                mismatches++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                mismatches++;
            end
            if (got.steps_completed !== want.steps_completed) begin
                $error("steps_completed: expected %0d, got %0d",
                       want.steps_completed, got.steps_completed);
                mismatches++;
            end
            if (got.start_rejected !== want.start_rejected) begin
                $error("start_rejected: expected %0d, got %0d",
                       want.start_rejected, got.start_rejected);
                mismatches++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    sptg_pkg::t_in_word              i_in_word;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    sptg_pkg::t_out_word             o_out_word;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [sptg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sptg_pkg::CNT_W-1:0]      i_cfg_data;

    int                send_idle_pct = 29;
    int                recv_idle_pct = 51;
    step_train_tracker tracker = new();

    step_pulse_train_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready)
            tracker.check_word(o_out_word);
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic sptg_pkg::t_in_word tick_req(logic start, logic stop);
        sptg_pkg::t_in_word w;
        w.start_req = start;
        w.stop_req  = stop;
        return w;
    endfunction

    function automatic sptg_pkg::t_in_word pick_tick();
        sptg_pkg::t_in_word w;
        int unsigned        r;
        w = '0;
        r = $urandom_range(99);
        if (r < 10) begin
            w = sptg_pkg::t_in_word'($urandom_range(3));
        end else if (!tracker.running) begin
            w.start_req = ($urandom_range(99) < 40);
        end else begin
            w.stop_req  = ($urandom_range(299) == 0);
            w.start_req = ($urandom_range(99) < 3);
        end
        return w;
    endfunction

    task automatic send_tick(input sptg_pkg::t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_tick(w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // drain outstanding words, then write both registers back to back
    task automatic retune(input logic [sptg_pkg::CNT_W-1:0] total,
                          input logic [sptg_pkg::FREQ_W-1:0] freq);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sptg_pkg::REG_TOTAL_STEPS;
        i_cfg_data  <= total;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= sptg_pkg::REG_STEP_FREQ_HZ;
        i_cfg_data  <= sptg_pkg::CNT_W'(freq);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_config(total, freq);
    endtask

    initial begin
        logic [sptg_pkg::CNT_W-1:0]  total;
        logic [sptg_pkg::FREQ_W-1:0] freq;
        int unsigned                 n_ticks;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= sptg_pkg::REG_TOTAL_STEPS;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(tick_req(1'b0, 1'b0));
        send_tick(tick_req(1'b0, 1'b1));
        send_tick(tick_req(1'b1, 1'b1));
        send_tick(tick_req(1'b1, 1'b0));
        send_tick(tick_req(1'b0, 1'b0));
        send_tick(tick_req(1'b1, 1'b1));
        send_tick(tick_req(1'b1, 1'b0));
        send_tick(tick_req(1'b0, 1'b1));
        retune(sptg_pkg::CNT_W'(0), sptg_pkg::FREQ_W'(1000));
        send_tick(tick_req(1'b1, 1'b0));
        retune(sptg_pkg::CNT_W'(2), sptg_pkg::FREQ_W'(0));
        send_tick(tick_req(1'b1, 1'b0));
        retune(sptg_pkg::CNT_W'(2), sptg_pkg::FREQ_W'(15));
        send_tick(tick_req(1'b1, 1'b0));
        send_tick(tick_req(1'b0, 1'b0));
        send_tick(tick_req(1'b0, 1'b1));
        retune(sptg_pkg::CNT_W'(2), sptg_pkg::FREQ_W'(1000000));
        send_tick(tick_req(1'b1, 1'b0));
        repeat (9) send_tick(tick_req(1'b0, 1'b0));

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    total   = sptg_pkg::CNT_W'(2147483647);
                    freq    = sptg_pkg::FREQ_W'(1048575);
                    n_ticks = 200;
                end
                1: begin
                    total   = sptg_pkg::CNT_W'(70);
                    freq    = sptg_pkg::FREQ_W'(250000);
                    n_ticks = 200;
                end
                2: begin
                    total   = sptg_pkg::CNT_W'(3);
                    freq    = sptg_pkg::FREQ_W'(16);
                    n_ticks = 50;
                end
                3: begin
                    total   = sptg_pkg::CNT_W'(130);
                    freq    = sptg_pkg::FREQ_W'(333333);
                    n_ticks = 200;
                end
                4: begin
                    total   = sptg_pkg::CNT_W'($urandom_range(1, 150));
                    freq    = sptg_pkg::FREQ_W'($urandom_range(100000, 1000000));
                    n_ticks = 150;
                end
                5: begin
                    total   = sptg_pkg::CNT_W'($urandom_range(1, 20));
                    freq    = sptg_pkg::FREQ_W'($urandom_range(62500, 1000000));
                    n_ticks = 150;
                end
                default: begin
                    total   = sptg_pkg::CNT_W'($urandom_range(1, 2147483647));
                    freq    = sptg_pkg::FREQ_W'($urandom_range(16, 1048575));
                    n_ticks = 100;
                end
            endcase
            send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 51 : 0;
            recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 29 : 0;
            retune(total, freq);
            repeat (n_ticks) send_tick(pick_tick());
        end

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
